[sv/fth_pkg.sv]
// ----------------------------------------------------------------------------
// fth_pkg: shared types and constants
// Field widths, operation codes and sequencer states of the frequency table.
// ----------------------------------------------------------------------------
package fth_pkg;

  localparam int KEY_W  = 16;
  localparam int CNT_W  = 16;
  localparam int TOPK_W = 6;
  localparam int WORD_W = KEY_W + CNT_W;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [CNT_W-1:0] COUNT_ONE = 16'd1;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_RD,
    ST_A_CMP,
    ST_APPEND,
    ST_SD_RDP,
    ST_SD_RDL,
    ST_SD_CL,
    ST_SD_CR,
    ST_SD_SW,
    ST_SD_SW2,
    ST_X_R0,
    ST_X_RI,
    ST_X_W0,
    ST_X_WI,
    ST_E_RD,
    ST_E_LD
  } state_t;

  typedef enum logic {
    PH_BUILD,
    PH_EXTRACT
  } phase_t;

endpackage

[sv/fth_ram.sv]
// ----------------------------------------------------------------------------
// fth_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module fth_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/frequency_table_heap_top_k.sv]
// ----------------------------------------------------------------------------
// frequency_table_heap_top_k: key frequency table with heap top-k readout
// Counts key occurrences and returns the k most frequent entries on query.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_stall): in_kind selects an add of in_item_key or a
// query of in_top_k entries. Result beats (out_valid/out_stall) carry one
// entry each, highest count first, out_last on the final one of a query.
// An add gives no result; a query with k of 0 or an empty table gives none.
// in_stall stays high while an item is in work; one item at a time.
// Sequencing, n = entries in use, all table traffic through one RAM port pair:
//   add:   reads and compares entries in turn; a match bumps its count, else
//          the key is appended after the last entry if the table has room.
//   query: n/2 build sift-downs, then k root swaps each followed by an extract
//          sift-down that reads a node and its children and swaps it with the
//          larger child per level (at most log2(n) + 1), then k results read out.
// The last result sits in an output register; the next item is taken while
// it waits. A stalled result holds the sequencer until the register frees.
// Reset clears the entry count and the output valid; table contents need no
// clearing since only entries in use are read.
// ----------------------------------------------------------------------------
module frequency_table_heap_top_k #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [fth_pkg::KEY_W-1:0]  in_item_key,
  input  logic [fth_pkg::TOPK_W-1:0] in_top_k,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fth_pkg::KEY_W-1:0]  out_result_key,
  output logic [fth_pkg::CNT_W-1:0]  out_result_count,
  output logic                       out_last
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = AW + 2;
  localparam int QW = (NW > fth_pkg::TOPK_W) ? NW : fth_pkg::TOPK_W;
  localparam int WW = fth_pkg::WORD_W;
  localparam int KW = fth_pkg::KEY_W;
  localparam int NCW = fth_pkg::CNT_W;

  fth_pkg::state_t state_r, state_nxt;
  fth_pkg::phase_t phase_r, phase_nxt;

  logic [NW-1:0]  used_r, used_nxt;
  logic [NW-1:0]  len_r, len_nxt;
  logic [NW-1:0]  bi_r, bi_nxt;
  logic [AW-1:0]  pos_r, pos_nxt;
  logic [AW-1:0]  big_r, big_nxt;
  logic [AW-1:0]  ei_r, ei_nxt;
  logic [AW-1:0]  lo_r, lo_nxt;
  logic [AW-1:0]  j_r, j_nxt;
  logic [KW-1:0]  key_r, key_nxt;
  logic [WW-1:0]  posv_r, posv_nxt;
  logic [WW-1:0]  bigv_r, bigv_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic [KW-1:0]  out_key_r, out_key_nxt;
  logic [NCW-1:0] out_cnt_r, out_cnt_nxt;
  logic           out_last_r, out_last_nxt;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [WW-1:0]  ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [WW-1:0]  ram_rdata;

  logic [KW-1:0]  rd_key;
  logic [NCW-1:0] rd_cnt;
  logic [NCW-1:0] bigv_cnt;
  logic [NCW-1:0] cnt_inc;
  logic [CW-1:0]  lc_w, rc_w, len_ext;
  logic [QW-1:0]  topk_ext, used_ext, kq_q;
  logic [NW-1:0]  kq_n, half;
  logic           sd_done;

  fth_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_key   = ram_rdata[WW-1:NCW];
  assign rd_cnt   = ram_rdata[NCW-1:0];
  assign bigv_cnt = bigv_r[NCW-1:0];
  assign cnt_inc  = (rd_cnt == fth_pkg::COUNT_MAX) ? rd_cnt : rd_cnt + NCW'(1);
  assign lc_w     = {1'b0, pos_r, 1'b1};
  assign rc_w     = lc_w + CW'(1);
  assign len_ext  = CW'(len_r);
  assign topk_ext = QW'(in_top_k);
  assign used_ext = QW'(used_r);
  assign kq_q     = (topk_ext < used_ext) ? topk_ext : used_ext;
  assign kq_n     = NW'(kq_q);
  assign half     = used_r >> 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fth_pkg::ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    len_r      <= len_nxt;
    bi_r       <= bi_nxt;
    pos_r      <= pos_nxt;
    big_r      <= big_nxt;
    ei_r       <= ei_nxt;
    lo_r       <= lo_nxt;
    j_r        <= j_nxt;
    key_r      <= key_nxt;
    posv_r     <= posv_nxt;
    bigv_r     <= bigv_nxt;
    out_key_r  <= out_key_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    used_nxt      = used_r;
    len_nxt       = len_r;
    bi_nxt        = bi_r;
    pos_nxt       = pos_r;
    big_nxt       = big_r;
    ei_nxt        = ei_r;
    lo_nxt        = lo_r;
    j_nxt         = j_r;
    key_nxt       = key_r;
    posv_nxt      = posv_r;
    bigv_nxt      = bigv_r;
    out_key_nxt   = out_key_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = bigv_r;
    ram_raddr     = pos_r;
    sd_done       = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      fth_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == fth_pkg::KIND_ADD) begin
            key_nxt = in_item_key;
            j_nxt   = '0;
            if (used_r == '0) begin
              state_nxt = fth_pkg::ST_APPEND;
            end else begin
              state_nxt = fth_pkg::ST_A_RD;
            end
          end else if (kq_n != '0) begin
            lo_nxt = AW'(used_r - kq_n);
            if (half == '0) begin
              ei_nxt    = AW'(used_r - NW'(1));
              state_nxt = fth_pkg::ST_X_R0;
            end else begin
              bi_nxt    = half;
              pos_nxt   = AW'(half - NW'(1));
              len_nxt   = used_r;
              phase_nxt = fth_pkg::PH_BUILD;
              state_nxt = fth_pkg::ST_SD_RDP;
            end
          end
        end
      end
      fth_pkg::ST_A_RD: begin
        ram_raddr = j_r;
        state_nxt = fth_pkg::ST_A_CMP;
      end
      fth_pkg::ST_A_CMP: begin
        ram_raddr = j_r;
        if (rd_key == key_r) begin
          ram_we    = 1'b1;
          ram_waddr = j_r;
          ram_wdata = {key_r, cnt_inc};
          state_nxt = fth_pkg::ST_IDLE;
        end else if (NW'(j_r) + NW'(1) == used_r) begin
          state_nxt = fth_pkg::ST_APPEND;
        end else begin
          j_nxt     = j_r + AW'(1);
          state_nxt = fth_pkg::ST_A_RD;
        end
      end
      fth_pkg::ST_APPEND: begin
        if (used_r < NW'(TABLE_DEPTH)) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(used_r);
          ram_wdata = {key_r, fth_pkg::COUNT_ONE};
          used_nxt  = used_r + NW'(1);
        end
        state_nxt = fth_pkg::ST_IDLE;
      end
      fth_pkg::ST_SD_RDP: begin
        ram_raddr = pos_r;
        state_nxt = fth_pkg::ST_SD_RDL;
      end
      fth_pkg::ST_SD_RDL: begin
        posv_nxt = ram_rdata;
        bigv_nxt = ram_rdata;
        big_nxt  = pos_r;
        if (lc_w < len_ext) begin
          ram_raddr = AW'(lc_w);
          state_nxt = fth_pkg::ST_SD_CL;
        end else begin
          sd_done = 1'b1;
        end
      end
      fth_pkg::ST_SD_CL: begin
        if (rd_cnt > bigv_cnt) begin
          big_nxt  = AW'(lc_w);
          bigv_nxt = ram_rdata;
        end
        if (rc_w < len_ext) begin
          ram_raddr = AW'(rc_w);
          state_nxt = fth_pkg::ST_SD_CR;
        end else begin
          state_nxt = fth_pkg::ST_SD_SW;
        end
      end
      fth_pkg::ST_SD_CR: begin
        if (rd_cnt > bigv_cnt) begin
          big_nxt  = AW'(rc_w);
          bigv_nxt = ram_rdata;
        end
        state_nxt = fth_pkg::ST_SD_SW;
      end
      fth_pkg::ST_SD_SW: begin
        if (big_r == pos_r) begin
          sd_done = 1'b1;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = bigv_r;
          state_nxt = fth_pkg::ST_SD_SW2;
        end
      end
      fth_pkg::ST_SD_SW2: begin
        ram_we    = 1'b1;
        ram_waddr = big_r;
        ram_wdata = posv_r;
        pos_nxt   = big_r;
        state_nxt = fth_pkg::ST_SD_RDP;
      end
      fth_pkg::ST_X_R0: begin
        ram_raddr = '0;
        state_nxt = fth_pkg::ST_X_RI;
      end
      fth_pkg::ST_X_RI: begin
        posv_nxt  = ram_rdata;
        ram_raddr = ei_r;
        state_nxt = fth_pkg::ST_X_W0;
      end
      fth_pkg::ST_X_W0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = ram_rdata;
        state_nxt = fth_pkg::ST_X_WI;
      end
      fth_pkg::ST_X_WI: begin
        ram_we    = 1'b1;
        ram_waddr = ei_r;
        ram_wdata = posv_r;
        pos_nxt   = '0;
        len_nxt   = NW'(ei_r);
        phase_nxt = fth_pkg::PH_EXTRACT;
        state_nxt = fth_pkg::ST_SD_RDP;
      end
      fth_pkg::ST_E_RD: begin
        ram_raddr = ei_r;
        state_nxt = fth_pkg::ST_E_LD;
      end
      fth_pkg::ST_E_LD: begin
        ram_raddr = ei_r;
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = rd_key;
          out_cnt_nxt   = rd_cnt;
          out_last_nxt  = (ei_r == lo_r);
          if (ei_r == lo_r) begin
            state_nxt = fth_pkg::ST_IDLE;
          end else begin
            ei_nxt    = ei_r - AW'(1);
            state_nxt = fth_pkg::ST_E_RD;
          end
        end
      end
      default: begin
        state_nxt = fth_pkg::ST_IDLE;
      end
    endcase

    if (sd_done) begin
      if (phase_r == fth_pkg::PH_BUILD) begin
        if (bi_r == NW'(1)) begin
          ei_nxt    = AW'(used_r - NW'(1));
          state_nxt = fth_pkg::ST_X_R0;
        end else begin
          bi_nxt    = bi_r - NW'(1);
          pos_nxt   = AW'(bi_r - NW'(2));
          state_nxt = fth_pkg::ST_SD_RDP;
        end
      end else begin
        if (ei_r == lo_r) begin
          ei_nxt    = AW'(used_r - NW'(1));
          state_nxt = fth_pkg::ST_E_RD;
        end else begin
          ei_nxt    = ei_r - AW'(1);
          state_nxt = fth_pkg::ST_X_R0;
        end
      end
    end
  end

  assign in_stall         = (state_r != fth_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_key   = out_key_r;
  assign out_result_count = out_cnt_r;
  assign out_last         = out_last_r;

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= NW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (used_r != $past(used_r)) |-> used_r == $past(used_r) + NW'(1))
    else $error("entry count moved by other than one");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r) == fth_pkg::ST_E_LD)
    else $error("result beat raised outside readout");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> NW'(ram_waddr) <= used_r)
    else $error("table write beyond entries in use");

endmodule

[verif/topk_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// topk_result_checker: frequency table ranking checker
// Watches the item and result channels of the frequency table. It keeps its
// own copy of the key/count table, replays every accepted add and query on it,
// and compares each result beat with the oldest predicted ranked entry.
// ----------------------------------------------------------------------------
module topk_result_checker #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_kind,
  input  logic [fth_pkg::KEY_W-1:0]  in_item_key,
  input  logic [fth_pkg::TOPK_W-1:0] in_top_k,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [fth_pkg::KEY_W-1:0]  out_result_key,
  input  logic [fth_pkg::CNT_W-1:0]  out_result_count,
  input  logic                       out_last,
  output int                         fail_count,
  output int                         pending_results
);

  typedef struct {
    logic [fth_pkg::KEY_W-1:0] rkey;
    logic [fth_pkg::CNT_W-1:0] rcount;
    logic                      rlast;
  } ranked_entry_t;

  logic [fth_pkg::KEY_W-1:0] key_tab [TABLE_DEPTH];
  logic [fth_pkg::CNT_W-1:0] cnt_tab [TABLE_DEPTH];
  int unsigned               used_entries = 0;
  ranked_entry_t             expected_ranks [$];
  int                        mismatches = 0;
  int                        waiting = 0;

  assign fail_count      = mismatches;
  assign pending_results = waiting;

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [fth_pkg::KEY_W-1:0] tk;
    logic [fth_pkg::CNT_W-1:0] tc;
    tk = key_tab[a];
    tc = cnt_tab[a];
    key_tab[a] = key_tab[b];
    cnt_tab[a] = cnt_tab[b];
    key_tab[b] = tk;
    cnt_tab[b] = tc;
  endfunction

  // strict greater-than sift-down within the first len slots
  function automatic void sift_heap(int unsigned len, int unsigned pos);
    int unsigned big;
    int unsigned lc;
    int unsigned rc;
    bit          moving;
    moving = 1'b1;
    while (moving) begin
      big = pos;
      lc  = 2 * pos + 1;
      rc  = 2 * pos + 2;
      if (lc < len && cnt_tab[lc] > cnt_tab[big]) big = lc;
      if (rc < len && cnt_tab[rc] > cnt_tab[big]) big = rc;
      if (big == pos) begin
        moving = 1'b0;
      end else begin
        swap_slots(pos, big);
        pos = big;
      end
    end
  endfunction

  function automatic void record_occurrence(logic [fth_pkg::KEY_W-1:0] key);
    bit found;
    found = 1'b0;
    for (int unsigned j = 0; j < used_entries; j++) begin
      if (!found && key_tab[j] == key) begin
        found = 1'b1;
        if (cnt_tab[j] != fth_pkg::COUNT_MAX) cnt_tab[j] = cnt_tab[j] + fth_pkg::COUNT_ONE;
      end
    end
    if (!found && used_entries < TABLE_DEPTH) begin
      key_tab[used_entries] = key;
      cnt_tab[used_entries] = fth_pkg::COUNT_ONE;
      used_entries++;
    end
  endfunction

  function automatic void rank_top_entries(int unsigned k_req);
    int unsigned   n;
    int unsigned   k;
    int unsigned   slot;
    ranked_entry_t e;
    n = used_entries;
    k = (k_req > n) ? n : k_req;
    if (k != 0) begin
      for (int unsigned i = n / 2; i > 0; i--) sift_heap(n, i - 1);
      for (int unsigned d = 0; d < k; d++) begin
        slot = n - 1 - d;
        swap_slots(0, slot);
        sift_heap(slot, 0);
      end
      for (int unsigned r = 0; r < k; r++) begin
        slot     = n - 1 - r;
        e.rkey   = key_tab[slot];
        e.rcount = cnt_tab[slot];
        e.rlast  = (r + 1 == k);
        expected_ranks = {expected_ranks, e};
      end
    end
  endfunction

  always @(posedge clk) begin
    ranked_entry_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_ranks.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat key %h count %0d last %b",
                   $time, out_result_key, out_result_count, out_last);
        end else begin
          e = expected_ranks.pop_front();
          if (out_result_key !== e.rkey) begin
            mismatches++;
            $display("%0t: result key expected %h got %h", $time, e.rkey, out_result_key);
          end
          if (out_result_count !== e.rcount) begin
            mismatches++;
            $display("%0t: result count expected %0d got %0d",
                     $time, e.rcount, out_result_count);
          end
          if (out_last !== e.rlast) begin
            mismatches++;
            $display("%0t: last flag expected %b got %b", $time, e.rlast, out_last);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == fth_pkg::KIND_ADD) record_occurrence(in_item_key);
        else rank_top_entries(in_top_k);
      end
      waiting = expected_ranks.size();
    end
  end

endmodule

[verif/frequency_table_heap_top_k_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frequency_table_heap_top_k_tb: frequency table top-k testbench
// Drives add and query beats into the frequency table: empty-table queries,
// a run of repeated adds of one key, extreme keys, clamped and zero k, ties,
// then random traffic over a key pool larger than the table so it fills and
// drops keys. Both sides idle at random; once the result side holds off for
// a long stretch so the block backs up. A checker beside the block predicts
// and compares every result beat.
// ----------------------------------------------------------------------------
module frequency_table_heap_top_k_tb;

  typedef logic [fth_pkg::KEY_W-1:0]  key_t;
  typedef logic [fth_pkg::TOPK_W-1:0] topk_t;

  localparam int          TABLE_DEPTH  = 32;
  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 11;
  localparam int          POOL_SIZE    = 40;
  localparam int          SAT_ADDS     = 8;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 4000;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam key_t        SAT_KEY      = 16'h5A3C;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_kind = fth_pkg::KIND_ADD;
  logic [fth_pkg::KEY_W-1:0]     in_item_key = '0;
  logic [fth_pkg::TOPK_W-1:0]    in_top_k = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [fth_pkg::KEY_W-1:0]     out_result_key;
  logic [fth_pkg::CNT_W-1:0]     out_result_count;
  logic                          out_last;

  int                fail_count;
  int                pending_results;
  int unsigned       cycle_count = 0;
  bit                no_gaps = 1'b0;
  bit                sink_free = 1'b0;
  bit                hold_request = 1'b0;
  key_t              key_pool [POOL_SIZE];

  always #(CLK_PERIOD / 2) clk = ~clk;

  frequency_table_heap_top_k #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_item_key     (in_item_key),
    .in_top_k        (in_top_k),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_key  (out_result_key),
    .out_result_count(out_result_count),
    .out_last        (out_last)
  );

  topk_result_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_item_key     (in_item_key),
    .in_top_k        (in_top_k),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_result_key  (out_result_key),
    .out_result_count(out_result_count),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("frequency_table_heap_top_k_tb NOT OK");
      $finish;
    end
  end

  task automatic offer_item(input logic kind, input key_t key, input topk_t k);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_item_key <= key;
    in_top_k    <= k;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic offer_random_item();
    int unsigned sel;
    key_t        key;
    topk_t       k;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      if ($urandom_range(0, 6) == 0) key = key_t'($urandom_range(0, 65535));
      else key = key_pool[$urandom_range(0, $urandom_range(0, POOL_SIZE - 1))];
      offer_item(fth_pkg::KIND_ADD, key, topk_t'($urandom_range(0, 63)));
    end else begin
      case ($urandom_range(0, 9))
        0:       k = '0;
        1:       k = topk_t'($urandom_range(33, 63));
        2:       k = topk_t'(TABLE_DEPTH);
        default: k = topk_t'($urandom_range(1, 8));
      endcase
      offer_item(fth_pkg::KIND_QUERY, key_t'($urandom_range(0, 65535)), k);
    end
  endtask

  // result side: random stall before each beat, one long hold on request
  initial begin : result_sink
    int unsigned stall_len;
    while (!rst_n) @(posedge clk);
    forever begin
      stall_len = sink_free ? 0 : $urandom_range(0, 12);
      if (hold_request) begin
        stall_len    = stall_len + HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall_len != 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    foreach (key_pool[i]) key_pool[i] = key_t'($urandom_range(0, 65535));
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table queries
    offer_item(fth_pkg::KIND_QUERY, 16'hFFFF, 6'd0);
    offer_item(fth_pkg::KIND_QUERY, 16'h0000, 6'd63);
    offer_item(fth_pkg::KIND_QUERY, 16'h1234, 6'd1);

    // repeated adds of one key, back to back
    no_gaps = 1'b1;
    repeat (SAT_ADDS) offer_item(fth_pkg::KIND_ADD, SAT_KEY, topk_t'($urandom_range(0, 63)));
    no_gaps = 1'b0;
    offer_item(fth_pkg::KIND_QUERY, 16'h0000, 6'd1);

    // extreme keys, zero and clamped k, ties
    offer_item(fth_pkg::KIND_ADD, 16'h0000, 6'd63);
    offer_item(fth_pkg::KIND_ADD, 16'hFFFF, 6'd0);
    offer_item(fth_pkg::KIND_ADD, 16'h0000, 6'd21);
    offer_item(fth_pkg::KIND_QUERY, 16'hFFFF, 6'd0);
    offer_item(fth_pkg::KIND_QUERY, 16'h0000, 6'd63);
    offer_item(fth_pkg::KIND_ADD, 16'h0001, 6'd0);
    offer_item(fth_pkg::KIND_ADD, 16'h8000, 6'd0);
    offer_item(fth_pkg::KIND_ADD, 16'h7FFF, 6'd0);
    offer_item(fth_pkg::KIND_ADD, 16'hAAAA, 6'd0);
    offer_item(fth_pkg::KIND_QUERY, 16'h5555, 6'd2);
    offer_item(fth_pkg::KIND_ADD, SAT_KEY, 6'd32);
    offer_item(fth_pkg::KIND_QUERY, 16'h0F0F, 6'd32);
    offer_item(fth_pkg::KIND_QUERY, 16'hF0F0, 6'd33);

    // random traffic; pool exceeds table depth so it fills and drops
    repeat (40) offer_random_item();
    no_gaps   = 1'b1;
    sink_free = 1'b1;
    repeat (30) offer_random_item();
    no_gaps   = 1'b0;
    sink_free = 1'b0;

    // receiver holds off while queries keep coming
    hold_request = 1'b1;
    no_gaps      = 1'b1;
    repeat (5) begin
      offer_item(fth_pkg::KIND_QUERY, key_t'($urandom_range(0, 65535)),
                 topk_t'($urandom_range(3, 10)));
      offer_item(fth_pkg::KIND_ADD, key_pool[$urandom_range(0, POOL_SIZE - 1)], 6'd0);
    end
    no_gaps = 1'b0;

    sink_free = 1'b1;
    repeat (25) offer_random_item();
    sink_free = 1'b0;
    repeat (25) offer_random_item();
    in_valid <= 1'b0;

    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("frequency_table_heap_top_k_tb OK");
    end else begin
      $display("frequency_table_heap_top_k_tb NOT OK");
    end
    $finish;
  end

endmodule
